@@ rtl/pcp_pkg.sv @@
// ----------------------------------------------------------------------------
// pcp_pkg
// shared widths and register codes of the carousel page picker
// ----------------------------------------------------------------------------
package pcp_pkg;

   localparam int RAND_W    = 16;   // random start value
   localparam int GLOB_W    = 14;   // position in the sent map
   localparam int PAGE_W    = 10;   // page index / per-channel count
   localparam int DIGIT_W   = 4;    // channel digit
   localparam int WORD_BITS = 32;   // bits per map word
   localparam int BIT_W     = 5;    // bit offset within a map word
   localparam int MAX_CHAN  = 9;
   localparam int LOW_CHAN  = 5;    // channels held in counts_low

   localparam int CSR_IDX_W = 2;
   localparam int CSR_DW    = 50;
   localparam int LOW_W     = 50;
   localparam int HIGH_W    = 40;

   localparam logic [CSR_IDX_W-1:0] CSR_HEADER_ENABLE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COUNTS_LOW    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COUNTS_HIGH   = 2'd2;

endpackage

@@ rtl/pcp_channels.sv @@
// ----------------------------------------------------------------------------
// pcp channels
// handshake interfaces of the request, response and csr channels
// ----------------------------------------------------------------------------
interface pcp_req_if;
   logic                      valid;
   logic                      ready;
   logic [pcp_pkg::RAND_W-1:0] random_value;
   modport source (output valid, output random_value, input ready);
   modport sink   (input valid, input random_value, output ready);
endinterface

interface pcp_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        valid_res;
   logic [pcp_pkg::DIGIT_W-1:0] channel_digit;
   logic [pcp_pkg::PAGE_W-1:0]  page_index;
   logic [pcp_pkg::GLOB_W-1:0]  global_index;
   logic                        header_send;
   logic                        restarted;
   modport source (output valid, output valid_res, output channel_digit,
                   output page_index, output global_index, output header_send,
                   output restarted, input ready);
   modport sink   (input valid, input valid_res, input channel_digit,
                   input page_index, input global_index, input header_send,
                   input restarted, output ready);
endinterface

interface pcp_csr_if;
   logic                          valid;
   logic                          ready;
   logic [pcp_pkg::CSR_IDX_W-1:0] index;
   logic [pcp_pkg::CSR_DW-1:0]    data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/pcp_mod_unit.sv @@
// ----------------------------------------------------------------------------
// pcp_mod_unit
// restoring remainder, one dividend bit per cycle
// ----------------------------------------------------------------------------
module pcp_mod_unit (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [pcp_pkg::RAND_W-1:0]   dividend,
   input  logic [pcp_pkg::GLOB_W-1:0]   divisor,
   output logic                         done,
   output logic [pcp_pkg::GLOB_W-1:0]   remainder
);
   localparam int CW = $clog2(pcp_pkg::RAND_W + 1);

   logic [pcp_pkg::RAND_W-1:0] quot_ff, quot_in;
   logic [pcp_pkg::GLOB_W-1:0] rem_ff, rem_in;
   logic [CW-1:0]              cnt_ff, cnt_in;
   logic                       busy_ff, busy_in;
   logic                       done_ff, done_in;
   logic [pcp_pkg::GLOB_W:0]   trial;

   always_comb begin
      trial   = {rem_ff, quot_ff[pcp_pkg::RAND_W-1]};
      quot_in = quot_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quot_in = dividend;
         rem_in  = '0;
         cnt_in  = CW'(pcp_pkg::RAND_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quot_in = {quot_ff[pcp_pkg::RAND_W-2:0], 1'b0};
         if (trial >= {1'b0, divisor}) begin
            rem_in = pcp_pkg::GLOB_W'(trial - {1'b0, divisor});
         end else begin
            rem_in = pcp_pkg::GLOB_W'(trial);
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      cnt_ff  <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done      = done_ff;
   assign remainder = rem_ff;
endmodule

@@ rtl/pcp_sent_ram.sv @@
// ----------------------------------------------------------------------------
// pcp_sent_ram
// sent map store, one write and one registered read port
// ----------------------------------------------------------------------------
module pcp_sent_ram #(
   parameter int DEPTH = 512,
   parameter int AW    = 9
) (
   input  logic                            clock,
   input  logic                            rd_en,
   input  logic [AW-1:0]                   rd_addr,
   output logic [pcp_pkg::WORD_BITS-1:0]   rd_data,
   input  logic                            wr_en,
   input  logic [AW-1:0]                   wr_addr,
   input  logic [pcp_pkg::WORD_BITS-1:0]   wr_data
);
   logic [pcp_pkg::WORD_BITS-1:0] mem [DEPTH];
   logic [pcp_pkg::WORD_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

@@ rtl/page_carousel_picker.sv @@
// ----------------------------------------------------------------------------
// page_carousel_picker
// carousel scheduler picking one not yet broadcast page per tick
// ----------------------------------------------------------------------------
// Each request item is one tick. The pages of channels 1 to 9 are laid end to
// end in a sent map held in a single-port-read, single-port-write memory of
// MAP_WORDS words of 32 bits. The tick's random value is reduced modulo the
// total page count (one bit a cycle), the map is then scanned one word at a
// time (read, then check) from the start page with wraparound, the first clear
// bit is set (one write) and the channel is found by walking the channel
// boundaries. When every page has been sent the map is cleared by a write pass
// over all MAP_WORDS words and restarted is raised. After reset the same
// clearing pass runs before the first request item is taken; csr writes are
// taken at all times. A zero total answers with all fields zero.
module page_carousel_picker #(
   parameter int MAP_WORDS = 512,
   parameter int CHANNELS  = 9
) (
   input  logic       clock,
   input  logic       reset,
   pcp_req_if.sink    req_chan,
   pcp_rsp_if.source  rsp_chan,
   pcp_csr_if.sink    csr_chan
);
   localparam int AW  = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam int CAP = MAP_WORDS * pcp_pkg::WORD_BITS;
   localparam int GW  = pcp_pkg::GLOB_W;
   localparam int VW  = GW - pcp_pkg::BIT_W + 1;   // word visit counter
   localparam int WB  = pcp_pkg::WORD_BITS;
   localparam int BW  = pcp_pkg::BIT_W;

   // sequencer codes
   localparam logic [2:0] ST_CLEAR  = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_MOD    = 3'd2;
   localparam logic [2:0] ST_READ   = 3'd3;
   localparam logic [2:0] ST_CHECK  = 3'd4;
   localparam logic [2:0] ST_WRITE  = 3'd5;
   localparam logic [2:0] ST_DECODE = 3'd6;
   localparam logic [2:0] ST_FINISH = 3'd7;

   // csr registers
   logic                      header_en_ff;
   logic [pcp_pkg::LOW_W-1:0]  counts_lo_ff;
   logic [pcp_pkg::HIGH_W-1:0] counts_hi_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         header_en_ff <= 1'b1;
         counts_lo_ff <= '0;
         counts_hi_ff <= '0;
      end else if (csr_chan.valid) begin
         case (csr_chan.index)
            pcp_pkg::CSR_HEADER_ENABLE: header_en_ff <= csr_chan.data[0];
            pcp_pkg::CSR_COUNTS_LOW:    counts_lo_ff <= csr_chan.data[pcp_pkg::LOW_W-1:0];
            pcp_pkg::CSR_COUNTS_HIGH:   counts_hi_ff <= csr_chan.data[pcp_pkg::HIGH_W-1:0];
            default: ;  // index beyond the register list
         endcase
      end
   end
   assign csr_chan.ready = 1'b1;

   // per-channel counts, unused channels count as empty
   logic [pcp_pkg::PAGE_W-1:0] chan_cnt [pcp_pkg::MAX_CHAN];
   logic [GW-1:0]              sum_all;
   logic [GW-1:0]              total_now;

   always_comb begin
      for (int i = 0; i < pcp_pkg::LOW_CHAN; i++) begin
         chan_cnt[i] = (i < CHANNELS) ? counts_lo_ff[i*pcp_pkg::PAGE_W +: pcp_pkg::PAGE_W]
                                      : '0;
      end
      for (int i = pcp_pkg::LOW_CHAN; i < pcp_pkg::MAX_CHAN; i++) begin
         chan_cnt[i] = (i < CHANNELS)
            ? counts_hi_ff[(i-pcp_pkg::LOW_CHAN)*pcp_pkg::PAGE_W +: pcp_pkg::PAGE_W]
            : '0;
      end
      sum_all = '0;
      for (int i = 0; i < pcp_pkg::MAX_CHAN; i++) begin
         sum_all = sum_all + GW'(chan_cnt[i]);
      end
      // saturate at the map size
      total_now = (32'(sum_all) > CAP) ? GW'(CAP) : sum_all;
   end

   // state
   logic [2:0]    state_ff, state_in;
   logic [AW-1:0] clr_addr_ff, clr_addr_in;
   logic          restart_ff, restart_in;
   logic          zero_ff, zero_in;
   logic [GW-1:0] total_ff, total_in;
   logic [GW-1:0] pos_ff, pos_in;        // scan position
   logic [GW-1:0] gstart_ff, gstart_in;  // start page of the tick
   logic [GW-1:0] g_ff, g_in;            // chosen page
   logic [WB-1:0] word_ff, word_in;
   logic [VW-1:0] visits_ff, visits_in;
   logic [3:0]    chan_ff, chan_in;
   logic [GW-1:0] cstart_ff, cstart_in;

   // response register
   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        out_valid_res_ff, out_valid_res_in;
   logic [pcp_pkg::DIGIT_W-1:0] out_digit_ff, out_digit_in;
   logic [pcp_pkg::PAGE_W-1:0]  out_page_ff, out_page_in;
   logic [GW-1:0]               out_glob_ff, out_glob_in;
   logic                        out_header_ff, out_header_in;
   logic                        out_restart_ff, out_restart_in;

   // remainder unit, dividend taken at the accepting edge
   logic          mod_start;
   logic          mod_done;
   logic [GW-1:0] mod_rem;
   logic [pcp_pkg::RAND_W-1:0] rand_ff, rand_in;

   pcp_mod_unit u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  (rand_in),
      .divisor   (total_ff),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   // sent map
   logic          rd_en;
   logic [AW-1:0] rd_addr;
   logic [WB-1:0] rd_data;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [WB-1:0] wr_data;

   pcp_sent_ram #(.DEPTH(MAP_WORDS), .AW(AW)) u_ram (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   // word check: first clear bit between the scan offset and the last page
   logic [GW-1:0]   last_page;
   logic [BW-1:0]   lo_bit, hi_bit;
   logic [WB-1:0]   cand;
   logic [BW-1:0]   first_bit;
   logic [GW-1:0]   word_base;
   logic [GW:0]     next_base;
   logic [VW-1:0]   words_used;
   logic [GW:0]     total_plus;
   logic [WB-1:0]   g_onehot;
   logic [GW-1:0]   chan_end;
   logic            out_free;

   always_comb begin
      last_page  = total_ff - 1'b1;
      lo_bit     = pos_ff[BW-1:0];
      hi_bit     = (last_page[GW-1:BW] == pos_ff[GW-1:BW]) ? last_page[BW-1:0] : '1;
      for (int j = 0; j < WB; j++) begin
         cand[j] = ~rd_data[j] && (BW'(j) >= lo_bit) && (BW'(j) <= hi_bit);
      end
      first_bit = '0;
      for (int j = WB - 1; j >= 0; j--) begin
         if (cand[j]) first_bit = BW'(j);
      end
      word_base  = {pos_ff[GW-1:BW], {BW{1'b0}}};
      next_base  = {1'b0, word_base} + (GW+1)'(WB);
      total_plus = {1'b0, total_ff} + (GW+1)'(WB - 1);
      words_used = VW'(total_plus >> BW);
      g_onehot   = WB'(1) << g_ff[BW-1:0];
      chan_end   = cstart_ff + GW'(chan_cnt[chan_ff]);
      out_free   = !rsp_valid_ff || rsp_chan.ready;
   end

   // sequencer
   always_comb begin
      state_in    = state_ff;
      clr_addr_in = clr_addr_ff;
      restart_in  = restart_ff;
      zero_in     = zero_ff;
      total_in    = total_ff;
      pos_in      = pos_ff;
      gstart_in   = gstart_ff;
      g_in        = g_ff;
      word_in     = word_ff;
      visits_in   = visits_ff;
      chan_in     = chan_ff;
      cstart_in   = cstart_ff;
      rand_in     = rand_ff;
      mod_start   = 1'b0;
      rd_en       = 1'b0;
      rd_addr     = AW'(pos_ff >> BW);
      wr_en       = 1'b0;
      wr_addr     = AW'(g_ff >> BW);
      wr_data     = word_ff | g_onehot;

      rsp_valid_in     = rsp_valid_ff && !rsp_chan.ready;
      out_valid_res_in = out_valid_res_ff;
      out_digit_in     = out_digit_ff;
      out_page_in      = out_page_ff;
      out_glob_in      = out_glob_ff;
      out_header_in    = out_header_ff;
      out_restart_in   = out_restart_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            // whole-map sweep; on a restart the chosen page's word keeps its bit
            wr_en   = 1'b1;
            wr_addr = clr_addr_ff;
            wr_data = (restart_ff && clr_addr_ff == AW'(g_ff >> BW)) ? g_onehot : '0;
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == AW'(MAP_WORDS - 1)) begin
               clr_addr_in = '0;
               if (restart_ff) begin
                  state_in  = ST_DECODE;
                  chan_in   = '0;
                  cstart_in = '0;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_IDLE: begin
            if (req_chan.valid) begin
               total_in   = total_now;
               rand_in    = req_chan.random_value;
               restart_in = 1'b0;
               zero_in    = (total_now == '0);
               state_in   = (total_now == '0) ? ST_FINISH : ST_MOD;
               mod_start  = (total_now != '0);
            end
         end
         ST_MOD: begin
            if (mod_done) begin
               pos_in    = mod_rem;
               gstart_in = mod_rem;
               visits_in = '0;
               state_in  = ST_READ;
            end
         end
         ST_READ: begin
            rd_en    = 1'b1;
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (cand != '0) begin
               g_in     = word_base + GW'(first_bit);
               word_in  = rd_data;
               state_in = ST_WRITE;
            end else if (visits_ff == words_used) begin
               // every page sent: restart from the start page
               g_in        = gstart_ff;
               restart_in  = 1'b1;
               clr_addr_in = '0;
               state_in    = ST_CLEAR;
            end else begin
               visits_in = visits_ff + 1'b1;
               pos_in    = (next_base >= {1'b0, total_ff}) ? '0 : GW'(next_base);
               state_in  = ST_READ;
            end
         end
         ST_WRITE: begin
            wr_en     = 1'b1;
            chan_in   = '0;
            cstart_in = '0;
            state_in  = ST_DECODE;
         end
         ST_DECODE: begin
            // walk channel boundaries until the page falls inside one
            if (g_ff < chan_end || chan_ff == 4'(pcp_pkg::MAX_CHAN - 1)) begin
               state_in = ST_FINISH;
            end else begin
               cstart_in = chan_end;
               chan_in   = chan_ff + 1'b1;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (zero_ff) begin
                  out_valid_res_in = 1'b0;
                  out_digit_in     = '0;
                  out_page_in      = '0;
                  out_glob_in      = '0;
                  out_header_in    = 1'b0;
                  out_restart_in   = 1'b0;
               end else begin
                  out_valid_res_in = 1'b1;
                  out_digit_in     = pcp_pkg::DIGIT_W'(chan_ff + 1'b1);
                  out_page_in      = pcp_pkg::PAGE_W'(g_ff - cstart_ff);
                  out_glob_in      = g_ff;
                  out_header_in    = header_en_ff;
                  out_restart_in   = restart_ff;
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      total_ff         <= total_in;
      pos_ff           <= pos_in;
      gstart_ff        <= gstart_in;
      g_ff             <= g_in;
      word_ff          <= word_in;
      visits_ff        <= visits_in;
      chan_ff          <= chan_in;
      cstart_ff        <= cstart_in;
      rand_ff          <= rand_in;
      zero_ff          <= zero_in;
      out_valid_res_ff <= out_valid_res_in;
      out_digit_ff     <= out_digit_in;
      out_page_ff      <= out_page_in;
      out_glob_ff      <= out_glob_in;
      out_header_ff    <= out_header_in;
      out_restart_ff   <= out_restart_in;
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         restart_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         restart_ff   <= restart_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_chan.ready         = (state_ff == ST_IDLE);
   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.valid_res     = out_valid_res_ff;
   assign rsp_chan.channel_digit = out_digit_ff;
   assign rsp_chan.page_index    = out_page_ff;
   assign rsp_chan.global_index  = out_glob_ff;
   assign rsp_chan.header_send   = out_header_ff;
   assign rsp_chan.restarted     = out_restart_ff;
endmodule
